@@ sv/scl_pkg.sv @@
// Shared types and codes for the snoopy coherence line transition unit.
`default_nettype none

package scl_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned PidW   = 4;
  localparam int unsigned StateW = 4;

  // line state codes
  localparam logic [StateW-1:0] ST_I  = 4'd0;
  localparam logic [StateW-1:0] ST_M  = 4'd1;
  localparam logic [StateW-1:0] ST_S  = 4'd2;
  localparam logic [StateW-1:0] ST_E  = 4'd3;
  localparam logic [StateW-1:0] ST_F  = 4'd4;
  localparam logic [StateW-1:0] ST_IM = 4'd5;
  localparam logic [StateW-1:0] ST_RP = 4'd6;
  localparam logic [StateW-1:0] ST_SM = 4'd7;
  localparam logic [StateW-1:0] ST_FM = 4'd8;

  // snooped bus requests
  localparam logic [1:0] REQ_RD   = 2'd0;
  localparam logic [1:0] REQ_WR   = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;
  localparam logic [1:0] REQ_SHR  = 2'd3;

  // protocol modes
  localparam logic [1:0] MODE_MI    = 2'd0;
  localparam logic [1:0] MODE_MSI   = 2'd1;
  localparam logic [1:0] MODE_MESI  = 2'd2;
  localparam logic [1:0] MODE_MESIF = 2'd3;

  // line data actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_INV  = 2'd1;
  localparam logic [1:0] ACT_RECV = 2'd2;

  // action field
  localparam logic ACCESS_LOCAL = 1'b0;
  localparam logic ACCESS_SNOOP = 1'b1;

  typedef struct packed {
    logic              action;
    logic              is_read_access;
    logic [1:0]        bus_request;
    logic [StateW-1:0] current_state;
    logic [AddrW-1:0]  line_address;
    logic [PidW-1:0]   processor_id;
  } item_t;

  typedef struct packed {
    logic [StateW-1:0] next_state;
    logic              permission_granted;
    logic [1:0]        line_action;
    logic              issue_bus_read;
    logic              issue_bus_write;
    logic              supply_data;
    logic              assert_shared;
    logic [AddrW-1:0]  message_address;
    logic [PidW-1:0]   message_processor;
    logic              bad_state;
  } result_t;

  // decoded transition, before message fields are attached
  typedef struct packed {
    logic [StateW-1:0] next_state;
    logic              perm;
    logic [1:0]        act;
    logic              rd;
    logic              wr;
    logic              data;
    logic              shr;
    logic              bad;
  } trans_t;

endpackage

`default_nettype wire

@@ sv/scl_next.sv @@
// Next-state and bus message decode for one cache line.
`default_nettype none

module scl_next (
  input  wire logic [1:0]                 mode_i,
  input  wire logic                       snoop_i,
  input  wire logic                       rd_i,
  input  wire logic [1:0]                 req_i,
  input  wire logic [scl_pkg::StateW-1:0] state_i,
  input  wire logic                       pid0_i,
  output scl_pkg::trans_t                 trans_o
);

  logic supported;

  always_comb begin
    unique case (state_i)
      scl_pkg::ST_I, scl_pkg::ST_M, scl_pkg::ST_IM: supported = 1'b1;
      scl_pkg::ST_S, scl_pkg::ST_RP, scl_pkg::ST_SM: supported = (mode_i >= scl_pkg::MODE_MSI);
      scl_pkg::ST_E:                 supported = (mode_i >= scl_pkg::MODE_MESI);
      scl_pkg::ST_F, scl_pkg::ST_FM: supported = (mode_i == scl_pkg::MODE_MESIF);
      default:                       supported = 1'b0;
    endcase
  end

  always_comb begin
    trans_o = '0;
    if (!supported) begin
      trans_o.next_state = scl_pkg::ST_I;
      trans_o.bad        = 1'b1;
    end else if (snoop_i == scl_pkg::ACCESS_SNOOP) begin
      trans_o.next_state = state_i;
      unique case (state_i)
        scl_pkg::ST_I: ;
        scl_pkg::ST_M: begin
          if (mode_i == scl_pkg::MODE_MI || req_i == scl_pkg::REQ_WR) begin
            trans_o.data       = 1'b1;
            trans_o.act        = scl_pkg::ACT_INV;
            trans_o.next_state = scl_pkg::ST_I;
          end else if (req_i == scl_pkg::REQ_RD) begin
            trans_o.data = 1'b1;
            trans_o.shr  = 1'b1;
            trans_o.act  = scl_pkg::ACT_INV;
            if (mode_i == scl_pkg::MODE_MSI) begin
              trans_o.next_state = scl_pkg::ST_I;
            end else if (mode_i == scl_pkg::MODE_MESIF && pid0_i) begin
              trans_o.next_state = scl_pkg::ST_F;
            end else begin
              trans_o.next_state = scl_pkg::ST_S;
            end
          end
        end
        scl_pkg::ST_E: begin
          if (req_i == scl_pkg::REQ_WR) begin
            trans_o.next_state = scl_pkg::ST_I;
          end else if (req_i == scl_pkg::REQ_RD) begin
            trans_o.next_state = scl_pkg::ST_S;
            if (mode_i == scl_pkg::MODE_MESIF && pid0_i) begin
              trans_o.shr        = 1'b1;
              trans_o.next_state = scl_pkg::ST_F;
            end else if (mode_i != scl_pkg::MODE_MESIF) begin
              trans_o.shr = 1'b1;
            end
          end
        end
        scl_pkg::ST_S: begin
          if (req_i == scl_pkg::REQ_WR) begin
            trans_o.next_state = scl_pkg::ST_I;
          end else if (req_i == scl_pkg::REQ_RD && mode_i == scl_pkg::MODE_MESI) begin
            trans_o.shr = 1'b1;
          end
        end
        scl_pkg::ST_F: begin
          if (req_i == scl_pkg::REQ_WR) begin
            trans_o.next_state = scl_pkg::ST_I;
          end else if (req_i == scl_pkg::REQ_RD) begin
            trans_o.shr        = 1'b1;
            trans_o.next_state = scl_pkg::ST_S;
          end
        end
        scl_pkg::ST_RP: begin
          if (req_i == scl_pkg::REQ_DATA) begin
            trans_o.act        = scl_pkg::ACT_RECV;
            trans_o.next_state = (mode_i == scl_pkg::MODE_MSI) ? scl_pkg::ST_S : scl_pkg::ST_E;
          end else if (req_i == scl_pkg::REQ_SHR) begin
            trans_o.act        = scl_pkg::ACT_RECV;
            trans_o.next_state = (mode_i == scl_pkg::MODE_MESIF) ? scl_pkg::ST_F : scl_pkg::ST_S;
          end
        end
        default: begin
          // write pending states: any data reply completes the upgrade
          if (req_i == scl_pkg::REQ_DATA || req_i == scl_pkg::REQ_SHR) begin
            trans_o.act        = scl_pkg::ACT_RECV;
            trans_o.next_state = scl_pkg::ST_M;
          end
        end
      endcase
    end else begin
      trans_o.next_state = state_i;
      unique case (state_i)
        scl_pkg::ST_I: begin
          if (rd_i && mode_i != scl_pkg::MODE_MI) begin
            trans_o.rd         = 1'b1;
            trans_o.next_state = scl_pkg::ST_RP;
          end else begin
            trans_o.wr         = 1'b1;
            trans_o.next_state = scl_pkg::ST_IM;
          end
        end
        scl_pkg::ST_M: trans_o.perm = 1'b1;
        scl_pkg::ST_E: begin
          trans_o.perm       = 1'b1;
          trans_o.next_state = rd_i ? scl_pkg::ST_E : scl_pkg::ST_M;
        end
        scl_pkg::ST_S, scl_pkg::ST_F: begin
          if (rd_i) begin
            trans_o.perm = 1'b1;
          end else begin
            trans_o.wr         = 1'b1;
            trans_o.next_state = (state_i == scl_pkg::ST_S) ? scl_pkg::ST_SM : scl_pkg::ST_FM;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/snoopy_coherence_line_fsm_unit.sv @@
// Top level of the snoopy coherence line transition unit.
// An accepted item passes the input register and then the result register before done_o shows it.
// Throughput: one item per cycle; busy stays low, the input and result registers overlap.
// The receiver cannot stall: done_o is high for a single cycle per result.
// Reset: protocol mode returns to MESI, no item in flight, done_o low.
`default_nettype none

module snoopy_coherence_line_fsm_unit #(
  parameter int unsigned ADDRESS_BITS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_wdata_i,
  input  wire logic             start,
  output logic                  busy,
  input  wire scl_pkg::item_t   item_i,
  output logic                  done_o,
  output scl_pkg::result_t      result_o
);

  logic [1:0]                 mode_q;
  logic                       valid_q;
  logic                       snoop_q;
  logic                       rd_q;
  logic [1:0]                 req_q;
  logic [scl_pkg::StateW-1:0] state_q;
  logic [ADDRESS_BITS-1:0]    addr_q;
  logic [scl_pkg::PidW-1:0]   pid_q;
  logic                       done_q;
  scl_pkg::result_t           res_q;
  scl_pkg::result_t           res_d;
  scl_pkg::trans_t            trans;
  logic                       any_msg;
  logic                       accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= scl_pkg::MODE_MESI;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      snoop_q <= item_i.action;
      rd_q    <= item_i.is_read_access;
      req_q   <= item_i.bus_request;
      state_q <= item_i.current_state;
      addr_q  <= item_i.line_address[ADDRESS_BITS-1:0];
      pid_q   <= item_i.processor_id;
    end
  end

  scl_next u_next (
    .mode_i  (mode_q),
    .snoop_i (snoop_q),
    .rd_i    (rd_q),
    .req_i   (req_q),
    .state_i (state_q),
    .pid0_i  (pid_q == '0),
    .trans_o (trans)
  );

  assign any_msg = trans.rd | trans.wr | trans.data | trans.shr;

  always_comb begin
    res_d.next_state         = trans.next_state;
    res_d.permission_granted = trans.perm;
    res_d.line_action        = trans.act;
    res_d.issue_bus_read     = trans.rd;
    res_d.issue_bus_write    = trans.wr;
    res_d.supply_data        = trans.data;
    res_d.assert_shared      = trans.shr;
    res_d.message_address    = any_msg ? scl_pkg::AddrW'(addr_q) : '0;
    res_d.message_processor  = any_msg ? pid_q : '0;
    res_d.bad_state          = trans.bad;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted item produced no result two cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result strobe without an accepted item");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.bad_state) |->
      (result_o.next_state == scl_pkg::ST_I && !result_o.permission_granted &&
       !result_o.issue_bus_read && !result_o.issue_bus_write &&
       !result_o.supply_data && !result_o.assert_shared))
    else $error("unsupported state result carries actions");

  a_snoop_no_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && snoop_q == scl_pkg::ACCESS_SNOOP) |=> !result_o.permission_granted)
    else $error("permission granted on a snooped request");

  a_msg_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.issue_bus_read && !result_o.issue_bus_write &&
     !result_o.supply_data && !result_o.assert_shared) |->
      (result_o.message_address == '0 && result_o.message_processor == '0))
    else $error("message fields set without a bus message");

endmodule

`default_nettype wire
